@@ sv/mrba_pkg.sv @@
// Shared types and codes of the multi-region bump allocator.
package mrba_pkg;

	// Value of the action field that loads a region.
	localparam logic ACT_LOAD = 1'b0;
	// Value of the action field that asks for an allocation.
	localparam logic ACT_ALLOC = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ZERO  = 2'd1;
	localparam logic [1:0] ST_NOMEM = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       latch;
		logic       load_commit;
		logic       scan_start;
		logic       scan_step;
		logic       hit_commit;
		logic       res_write;
		logic [1:0] res_status;
		logic       out_push;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_load;
		logic table_full;
		logic zero_req;
		logic no_region;
		logic cand_vld;
		logic cand_fit;
		logic out_free;
	} ctrl_sts_t;

endpackage

@@ sv/mrba_req_if.sv @@
// Request channel: one transaction is a load or an allocate item.
interface mrba_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] region_base;
	logic [31:0] region_limit;
	logic [31:0] request_bytes;

	modport source (
		output valid, action, region_base, region_limit, request_bytes,
		input  ready
	);
	modport sink (
		input  valid, action, region_base, region_limit, request_bytes,
		output ready
	);
endinterface

@@ sv/mrba_rsp_if.sv @@
// Response channel: one transaction is a granted address and a status.
interface mrba_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic [1:0]  status;

	modport source (
		output valid, address, status,
		input  ready
	);
	modport sink (
		input  valid, address, status,
		output ready
	);
endinterface

@@ sv/multi_region_bump_allocator_top.sv @@
// Top level of the multi-region bump allocator.
//
// This block keeps a table of up to MAX_REGIONS memory regions, each with a
// bump pointer and an exclusive limit, and answers every request transaction
// with exactly one response transaction. A load (action 0) appends a region
// whose bump pointer starts at its base; when the table is full the load is
// dropped and answered with status 3. An allocate (action 1) of zero bytes
// answers status 1; with no current region it answers status 2. Otherwise the
// block scans forward from the current region and grants the first region
// whose remaining space covers the request, returning its bump pointer and
// advancing it; if none fits it answers status 2 and nothing changes. The
// current region advances only when a grant fills a region exactly, and after
// the last region is filled the block is exhausted until the next load. A
// region whose limit lies below its pointer has no space. Addresses are zero
// on every response that is not a grant. The block handles one request at a
// time: it latches the request, decides it, scans the regions if the
// allocate needs a search (the region tables have a single registered read
// port, read one region per cycle), and then moves the result into an
// output register. The response sits in that register, so the next request
// is accepted while an earlier response waits to be taken. The region
// tables need no clearing after reset.
module multi_region_bump_allocator_top #(
	parameter int MAX_REGIONS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	mrba_req_if.sink   req,
	mrba_rsp_if.source rsp
);

	// Command and status between the sequencer and the datapath.
	mrba_pkg::ctrl_cmd_t cmd;
	mrba_pkg::ctrl_sts_t sts;

	// The sequencer owns the request handshake and steps the scan.
	mrba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the region tables, the allocator state and the
	// response register that drives the response channel.
	mrba_dp #(
		.MAX_REGIONS (MAX_REGIONS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.req_action        (req.action),
		.req_region_base   (req.region_base),
		.req_region_limit  (req.region_limit),
		.req_request_bytes (req.request_bytes),
		.rsp_ready         (rsp.ready),
		.rsp_valid         (rsp.valid),
		.rsp_address       (rsp.address),
		.rsp_status        (rsp.status)
	);

endmodule

@@ sv/mrba_ctrl.sv @@
// Controller state machine of the multi-region bump allocator.
module mrba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mrba_pkg::ctrl_sts_t sts,
	output mrba_pkg::ctrl_cmd_t cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECIDE = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.res_write = 1'b1;
				state_d       = S_DONE;
				if (sts.is_load) begin
					if (sts.table_full) begin
						cmd.res_status = mrba_pkg::ST_FULL;
					end else begin
						cmd.load_commit = 1'b1;
						cmd.res_status  = mrba_pkg::ST_OK;
					end
				end else if (sts.zero_req) begin
					cmd.res_status = mrba_pkg::ST_ZERO;
				end else if (sts.no_region) begin
					cmd.res_status = mrba_pkg::ST_NOMEM;
				end else begin
					cmd.res_write  = 1'b0;
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!sts.cand_vld) begin
					cmd.res_write  = 1'b1;
					cmd.res_status = mrba_pkg::ST_NOMEM;
					state_d        = S_DONE;
				end else if (sts.cand_fit) begin
					cmd.hit_commit = 1'b1;
					cmd.res_write  = 1'b1;
					cmd.res_status = mrba_pkg::ST_OK;
					state_d        = S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/mrba_dp.sv @@
// Datapath of the multi-region bump allocator: region tables, pointers and result register.
module mrba_dp #(
	parameter int MAX_REGIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mrba_pkg::ctrl_cmd_t cmd,
	output mrba_pkg::ctrl_sts_t sts,
	input  logic                req_action,
	input  logic [31:0]         req_region_base,
	input  logic [31:0]         req_region_limit,
	input  logic [31:0]         req_request_bytes,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output logic [31:0]         rsp_address,
	output logic [1:0]          rsp_status
);

	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

	// Latched item.
	logic        act_q;
	logic [31:0] base_q;
	logic [31:0] limit_q;
	logic [31:0] bytes_q;

	// Allocator state.
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] cur_q;
	logic             exh_q;

	// Region tables.
	logic [31:0] limit_mem [MAX_REGIONS];
	logic [31:0] bump_mem  [MAX_REGIONS];

	// Scan pointer and the candidate being checked.
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] rd_sel;
	logic             issue;
	logic             chk_vld_s1;
	logic [CNT_W-1:0] chk_idx_s1;
	logic [CNT_W-1:0] chk_next;
	logic [31:0]      rd_limit_s1;
	logic [31:0]      rd_bump_s1;
	logic [31:0]      room;

	// Pending result and output register.
	logic [31:0] res_addr_q;
	logic [1:0]  res_status_q;
	logic        out_valid_q;
	logic [31:0] out_addr_q;
	logic [1:0]  out_status_q;

	assign rd_sel   = cmd.scan_start ? CNT_W'(cur_q) : rd_idx_q;
	assign issue    = cmd.scan_start | cmd.scan_step;
	assign chk_next = chk_idx_s1 + CNT_W'(1);
	assign room     = (rd_limit_s1 >= rd_bump_s1) ? (rd_limit_s1 - rd_bump_s1) : 32'd0;

	always_comb begin
		sts            = '0;
		sts.is_load    = (act_q == mrba_pkg::ACT_LOAD);
		sts.table_full = (count_q == CNT_W'(MAX_REGIONS));
		sts.zero_req   = (bytes_q == 32'd0);
		sts.no_region  = (count_q == '0) || exh_q || (CNT_W'(cur_q) >= count_q);
		sts.cand_vld   = chk_vld_s1;
		sts.cand_fit   = (bytes_q <= room);
		sts.out_free   = !out_valid_q || rsp_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q   <= req_action;
			base_q  <= req_region_base;
			limit_q <= req_region_limit;
			bytes_q <= req_request_bytes;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_commit) begin
			limit_mem[count_q[IDX_W-1:0]] <= limit_q;
			bump_mem[count_q[IDX_W-1:0]]  <= base_q;
		end else if (cmd.hit_commit) begin
			bump_mem[chk_idx_s1[IDX_W-1:0]] <= rd_bump_s1 + bytes_q;
		end
		if (issue) begin
			rd_limit_s1 <= limit_mem[rd_sel[IDX_W-1:0]];
			rd_bump_s1  <= bump_mem[rd_sel[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			cur_q      <= '0;
			exh_q      <= 1'b0;
			rd_idx_q   <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
		end else begin
			if (cmd.load_commit) begin
				count_q <= count_q + CNT_W'(1);
				if (exh_q) begin
					exh_q <= 1'b0;
					cur_q <= count_q[IDX_W-1:0];
				end
			end else if (cmd.hit_commit && (bytes_q == room)) begin
				// An exact fill moves the scan start past the filled region, or marks the block exhausted if it was the last.
				if (chk_next < count_q) begin
					cur_q <= chk_next[IDX_W-1:0];
				end else begin
					exh_q <= 1'b1;
				end
			end
			if (issue) begin
				chk_vld_s1 <= (rd_sel < count_q);
				chk_idx_s1 <= rd_sel;
				rd_idx_q   <= rd_sel + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_write) begin
			res_status_q <= cmd.res_status;
			res_addr_q   <= cmd.hit_commit ? rd_bump_s1 : 32'd0;
		end
		if (cmd.out_push) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_push) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign rsp_address = out_addr_q;
	assign rsp_status  = out_status_q;

endmodule
